>>> rtl/atrp_pkg.sv
// ----------------------------------------------------------------------------
// atrp_pkg: shared types, widths and constants for the tilt calculator
// Holds the CORDIC datapath widths, the arctangent table, the stage payload
// types and the angle rounding and saturation function.
// ----------------------------------------------------------------------------
package atrp_pkg;

    // Number of CORDIC micro-rotations per angle and output fraction bits.
    localparam int CORDIC_STEPS        = 16;
    localparam int ANGLE_FRACTION_BITS = 7;

    // Fixed formats of the datapath.
    localparam int SAMPLE_W   = 16;
    localparam int GUARD_BITS = 8;
    localparam int ANGLE_Q    = 16;
    localparam int TABLE_LEN  = 24;
    localparam int DW         = 28;   // CORDIC x/y width, holds gain growth
    localparam int ANG_W      = 25;   // Q16 degree accumulator width
    localparam int GAIN_W     = 18;
    localparam int PROD_W     = SAMPLE_W + 1 + GAIN_W;
    localparam int ROLL_W     = 16;
    localparam int PITCH_W    = 15;

    localparam int GAIN_Q16   = 107922;
    localparam int DEG90_Q16  = 5898240;
    localparam int DEG180_Q16 = 11796480;
    localparam int OUT_SHIFT  = ANGLE_Q - ANGLE_FRACTION_BITS;

    // Vector and angle carried through each CORDIC stage.
    typedef struct packed {
        logic signed [DW-1:0]    x;
        logic signed [DW-1:0]    y;
        logic signed [ANG_W-1:0] ang;
    } vec_t;

    // Side information that rides along with each item.
    typedef struct packed {
        logic signed [PROD_W-1:0] prod;
        logic                     roll_zero;
        logic                     pitch_zero;
        logic [ROLL_W-1:0]        roll;
    } side_t;

    // atan(2^-i) in degrees, Q16, rounded to nearest.
    function automatic logic signed [ANG_W-1:0] atan_q16(input int idx);
        logic signed [ANG_W-1:0] v;
        unique case (idx)
            0:       v = ANG_W'(2949120);
            1:       v = ANG_W'(1740967);
            2:       v = ANG_W'(919879);
            3:       v = ANG_W'(466945);
            4:       v = ANG_W'(234379);
            5:       v = ANG_W'(117304);
            6:       v = ANG_W'(58666);
            7:       v = ANG_W'(29335);
            8:       v = ANG_W'(14668);
            9:       v = ANG_W'(7334);
            10:      v = ANG_W'(3667);
            11:      v = ANG_W'(1833);
            12:      v = ANG_W'(917);
            13:      v = ANG_W'(458);
            14:      v = ANG_W'(229);
            15:      v = ANG_W'(115);
            16:      v = ANG_W'(57);
            17:      v = ANG_W'(29);
            18:      v = ANG_W'(14);
            19:      v = ANG_W'(7);
            20:      v = ANG_W'(4);
            21:      v = ANG_W'(2);
            22:      v = ANG_W'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a Q16 angle to +-limit, then round to nearest (ties up) at the
    // output fraction width.
    function automatic logic signed [ANG_W-1:0] to_output(
        input logic signed [ANG_W-1:0] a,
        input logic signed [ANG_W-1:0] limit
    );
        logic signed [ANG_W-1:0] c;
        logic signed [ANG_W-1:0] r;
        logic signed [ANG_W-1:0] lim_out;
        c = a;
        if (c > limit)
        begin
            c = limit;
        end
        if (c < -limit)
        begin
            c = -limit;
        end
        r       = (c + (ANG_W'(1) <<< (OUT_SHIFT - 1))) >>> OUT_SHIFT;
        lim_out = limit >>> OUT_SHIFT;
        if (r > lim_out)
        begin
            r = lim_out;
        end
        if (r < -lim_out)
        begin
            r = -lim_out;
        end
        return r;
    endfunction

endpackage

>>> rtl/atrp_pre.sv
// ----------------------------------------------------------------------------
// atrp_pre: input stage
// Scales the sample, folds the (z, y) vector into the right half-plane,
// forms the gain-scaled -x product and flags the zero vectors.
// ----------------------------------------------------------------------------
module atrp_pre (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 in_valid,
    input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_z,
    output logic                                 out_valid,
    output atrp_pkg::vec_t                       out_vec,
    output atrp_pkg::side_t                      out_side
);
    import atrp_pkg::*;

    logic                     valid_reg;
    vec_t                     vec_reg;
    vec_t                     vec_next;
    side_t                    side_reg;
    side_t                    side_next;
    logic signed [DW-1:0]     zs;
    logic signed [DW-1:0]     ys;
    logic signed [SAMPLE_W:0] neg_x;

    // Scale by the guard bits and turn a left half-plane vector by 90 degrees.
    always_comb
    begin
        zs = DW'(accel_z) <<< GUARD_BITS;
        ys = DW'(accel_y) <<< GUARD_BITS;
        vec_next.x   = zs;
        vec_next.y   = ys;
        vec_next.ang = '0;
        if (zs < 0)
        begin
            if (ys >= 0)
            begin
                vec_next.x   = ys;
                vec_next.y   = -zs;
                vec_next.ang = ANG_W'(DEG90_Q16);
            end
            else
            begin
                vec_next.x   = -ys;
                vec_next.y   = zs;
                vec_next.ang = -ANG_W'(DEG90_Q16);
            end
        end
    end

    // Gain-scaled -x product and the zero-vector flags.
    always_comb
    begin
        neg_x                = -((SAMPLE_W + 1)'(accel_x));
        side_next.prod       = PROD_W'(neg_x) * PROD_W'(GAIN_Q16);
        side_next.roll_zero  = (accel_y == '0) && (accel_z == '0);
        side_next.pitch_zero = (accel_x == '0) && (accel_y == '0) && (accel_z == '0);
        side_next.roll       = '0;
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg  <= vec_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/atrp_cordic.sv
// ----------------------------------------------------------------------------
// atrp_cordic: unrolled vectoring CORDIC pipeline
// One micro-rotation per register stage; the side information and the valid
// bit move with the vector.
// ----------------------------------------------------------------------------
module atrp_cordic (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  atrp_pkg::vec_t  in_vec,
    input  atrp_pkg::side_t in_side,
    output logic            out_valid,
    output atrp_pkg::vec_t  out_vec,
    output atrp_pkg::side_t out_side
);
    import atrp_pkg::*;

    logic  valid_reg [CORDIC_STEPS];
    vec_t  vec_reg   [CORDIC_STEPS];
    side_t side_reg  [CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic  cur_valid;
        vec_t  cur_vec;
        side_t cur_side;
        vec_t  vec_next;

        if (i == 0)
        begin : g_first
            assign cur_valid = in_valid;
            assign cur_vec   = in_vec;
            assign cur_side  = in_side;
        end
        else
        begin : g_rest
            assign cur_valid = valid_reg[i-1];
            assign cur_vec   = vec_reg[i-1];
            assign cur_side  = side_reg[i-1];
        end

        // Rotate toward the x axis by atan(2^-i).
        always_comb
        begin
            if (cur_vec.y >= 0)
            begin
                vec_next.x   = cur_vec.x + (cur_vec.y >>> i);
                vec_next.y   = cur_vec.y - (cur_vec.x >>> i);
                vec_next.ang = cur_vec.ang + atan_q16(i);
            end
            else
            begin
                vec_next.x   = cur_vec.x - (cur_vec.y >>> i);
                vec_next.y   = cur_vec.y + (cur_vec.x >>> i);
                vec_next.ang = cur_vec.ang - atan_q16(i);
            end
        end

        // Valid bit of this stage.
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i] <= cur_valid;
            end
        end

        // Payload of this stage.
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                vec_reg[i]  <= vec_next;
                side_reg[i] <= cur_side;
            end
        end
    end

    assign out_valid = valid_reg[CORDIC_STEPS-1];
    assign out_vec   = vec_reg[CORDIC_STEPS-1];
    assign out_side  = side_reg[CORDIC_STEPS-1];

endmodule

>>> rtl/atrp_mid.sv
// ----------------------------------------------------------------------------
// atrp_mid: roll result and pitch setup
// Rounds and saturates the roll angle and builds the pitch vector from the
// gain-scaled magnitude and the gain-scaled -x term.
// ----------------------------------------------------------------------------
module atrp_mid (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  atrp_pkg::vec_t  in_vec,
    input  atrp_pkg::side_t in_side,
    output logic            out_valid,
    output atrp_pkg::vec_t  out_vec,
    output atrp_pkg::side_t out_side
);
    import atrp_pkg::*;

    logic                        valid_reg;
    vec_t                        vec_reg;
    vec_t                        vec_next;
    side_t                       side_reg;
    side_t                       side_next;
    logic signed [PROD_W-1:0]    prod_rnd;
    logic signed [PROD_W-9:0]    nx;
    logic signed [ANG_W-1:0]     roll_q;

    // Roll rounding; -x * K rounded to nearest at the datapath scale.
    always_comb
    begin
        prod_rnd = in_side.prod + PROD_W'(128);
        nx       = prod_rnd[PROD_W-1:8];
        if (in_side.roll_zero)
        begin
            roll_q = '0;
        end
        else
        begin
            roll_q = to_output(in_vec.ang, ANG_W'(DEG180_Q16));
        end
        vec_next.x     = in_vec.x;
        vec_next.y     = DW'(nx);
        vec_next.ang   = '0;
        side_next      = in_side;
        side_next.roll = roll_q[ROLL_W-1:0];
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            vec_reg  <= vec_next;
            side_reg <= side_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_vec   = vec_reg;
    assign out_side  = side_reg;

endmodule

>>> rtl/atrp_post.sv
// ----------------------------------------------------------------------------
// atrp_post: output stage
// Rounds and saturates the pitch angle and holds the result in the output
// register until it is transferred.
// ----------------------------------------------------------------------------
module atrp_post (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  atrp_pkg::vec_t                      in_vec,
    input  atrp_pkg::side_t                     in_side,
    output logic                                out_valid,
    output logic signed [atrp_pkg::ROLL_W-1:0]  roll_angle,
    output logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle
);
    import atrp_pkg::*;

    logic                      valid_reg;
    logic signed [ROLL_W-1:0]  roll_reg;
    logic signed [PITCH_W-1:0] pitch_reg;
    logic signed [ANG_W-1:0]   pitch_q;

    // Pitch rounding; the all-zero sample gives zero.
    always_comb
    begin
        if (in_side.pitch_zero)
        begin
            pitch_q = '0;
        end
        else
        begin
            pitch_q = to_output(in_vec.ang, ANG_W'(DEG90_Q16));
        end
    end

    // Valid bit.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    // Output payload registers.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            roll_reg  <= in_side.roll;
            pitch_reg <= pitch_q[PITCH_W-1:0];
        end
    end

    assign out_valid   = valid_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;

endmodule

>>> rtl/accel_tilt_roll_pitch.sv
// ----------------------------------------------------------------------------
// accel_tilt_roll_pitch: roll and pitch from a three-axis accelerometer
// Roll is atan2(y, z), pitch is atan2(-x, |y, z|), both in degrees with
// ANGLE_FRACTION_BITS fraction bits, from two chained CORDIC pipelines.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+----------------------------------
//   sample   | sample_valid, sample_stall | accel_x, accel_y, accel_z
//   angle    | angle_valid, angle_stall   | roll_angle, pitch_angle
//
// One sample is taken per clock while sample_stall is low, with one register
// stage per micro-rotation in each CORDIC pipeline.
// All stages advance together; a stalled result in the output register
// freezes the whole pipeline and asserts sample_stall.
// Reset clears only the valid bits.
// ----------------------------------------------------------------------------
module accel_tilt_roll_pitch (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 sample_valid,
    output logic                                 sample_stall,
    input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_x,
    input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_y,
    input  logic signed [atrp_pkg::SAMPLE_W-1:0] accel_z,
    output logic                                 angle_valid,
    input  logic                                 angle_stall,
    output logic signed [atrp_pkg::ROLL_W-1:0]   roll_angle,
    output logic signed [atrp_pkg::PITCH_W-1:0]  pitch_angle
);
    import atrp_pkg::*;

    logic  en;
    logic  pre_valid;
    vec_t  pre_vec;
    side_t pre_side;
    logic  roll_valid;
    vec_t  roll_vec;
    side_t roll_side;
    logic  mid_valid;
    vec_t  mid_vec;
    side_t mid_side;
    logic  pitch_valid;
    vec_t  pitch_vec;
    side_t pitch_side;

    // The pipeline moves unless a result waits in the output register.
    assign en           = !(angle_valid && angle_stall);
    assign sample_stall = !en;

    atrp_pre u_pre (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sample_valid),
        .accel_x   (accel_x),
        .accel_y   (accel_y),
        .accel_z   (accel_z),
        .out_valid (pre_valid),
        .out_vec   (pre_vec),
        .out_side  (pre_side)
    );

    // Roll CORDIC on (z, y).
    atrp_cordic u_roll (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (pre_valid),
        .in_vec    (pre_vec),
        .in_side   (pre_side),
        .out_valid (roll_valid),
        .out_vec   (roll_vec),
        .out_side  (roll_side)
    );

    atrp_mid u_mid (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (roll_valid),
        .in_vec    (roll_vec),
        .in_side   (roll_side),
        .out_valid (mid_valid),
        .out_vec   (mid_vec),
        .out_side  (mid_side)
    );

    // Pitch CORDIC on (magnitude, -x); the gain cancels.
    atrp_cordic u_pitch (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (mid_valid),
        .in_vec    (mid_vec),
        .in_side   (mid_side),
        .out_valid (pitch_valid),
        .out_vec   (pitch_vec),
        .out_side  (pitch_side)
    );

    atrp_post u_post (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (pitch_valid),
        .in_vec      (pitch_vec),
        .in_side     (pitch_side),
        .out_valid   (angle_valid),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle)
    );

endmodule

>>> rtl/atrp_checker.sv
// ----------------------------------------------------------------------------
// atrp_checker: port-level checks for the tilt calculator
// Watches the handshakes and the result ranges on the top-level ports.
// ----------------------------------------------------------------------------
module atrp_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                sample_stall,
    input logic                                angle_valid,
    input logic                                angle_stall,
    input logic signed [atrp_pkg::ROLL_W-1:0]  roll_angle,
    input logic signed [atrp_pkg::PITCH_W-1:0] pitch_angle
);
    import atrp_pkg::*;

    localparam int ROLL_LIM  = 180 * (1 << ANGLE_FRACTION_BITS);
    localparam int PITCH_LIM = 90 * (1 << ANGLE_FRACTION_BITS);

    // A stalled result stays valid and unchanged.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid && angle_stall |=> angle_valid && $stable(roll_angle)
                                       && $stable(pitch_angle))
    else $error("stalled result dropped or changed");

    // Input back-pressure follows exactly a waiting output.
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall == (angle_valid && angle_stall))
    else $error("sample_stall does not match output back-pressure");

    // Roll stays within plus and minus 180 degrees.
    a_roll: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (roll_angle <= ROLL_LIM) && (roll_angle >= -ROLL_LIM))
    else $error("roll out of range");

    // Pitch stays within plus and minus 90 degrees.
    a_pitch: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (pitch_angle <= PITCH_LIM) && (pitch_angle >= -PITCH_LIM))
    else $error("pitch out of range");

endmodule

bind accel_tilt_roll_pitch atrp_checker u_atrp_checker (.*);

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the accelerometer tilt calculator
// Drives three-axis samples through the sample channel and compares every
// roll and pitch result against an in-bench CORDIC predictor, in order.
// The sender works in bursts with gaps and the receiver stalls on patterns.
// ----------------------------------------------------------------------------
module tb_top;

    import atrp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 2 * CORDIC_STEPS + 12;

    // Expected angles for one sample.
    typedef struct packed {
        logic signed [ROLL_W-1:0]  roll;
        logic signed [PITCH_W-1:0] pitch;
    } tilt_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         sample_valid = 1'b0;
    logic                         sample_stall;
    logic signed [SAMPLE_W-1:0]   accel_x = '0;
    logic signed [SAMPLE_W-1:0]   accel_y = '0;
    logic signed [SAMPLE_W-1:0]   accel_z = '0;
    logic                         angle_valid;
    logic                         angle_stall = 1'b0;
    logic signed [ROLL_W-1:0]     roll_angle;
    logic signed [PITCH_W-1:0]    pitch_angle;

    // atan(2^-i) in degrees, Q16, rounded to nearest.
    longint atan_deg_tab [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    tilt_t  pending_tilt_q [$];
    int     fault_count = 0;
    int     cycle_count = 0;
    int     burst_left = 0;
    bit     sender_calm = 1'b0;
    int     stall_mode = 0;
    int     stall_left = 0;

    accel_tilt_roll_pitch u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .accel_x      (accel_x),
        .accel_y      (accel_y),
        .accel_z      (accel_z),
        .angle_valid  (angle_valid),
        .angle_stall  (angle_stall),
        .roll_angle   (roll_angle),
        .pitch_angle  (pitch_angle)
    );

    // Clock with a period of 10.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Vectoring CORDIC: drives vy toward zero and accumulates the angle.
    function automatic void cordic_vectoring(inout longint vx, inout longint vy,
                                             inout longint ang);
        longint dx;
        longint dy;
        for (int i = 0; i < CORDIC_STEPS && i < TABLE_LEN; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (vy >= 0)
            begin
                vx  = vx + dx;
                vy  = vy - dy;
                ang = ang + atan_deg_tab[i];
            end
            else
            begin
                vx  = vx - dx;
                vy  = vy + dy;
                ang = ang - atan_deg_tab[i];
            end
        end
    endfunction

    // Clamp a Q16 degree angle, then round it to the output fraction width.
    function automatic longint round_angle(input longint a, input longint lim);
        int     sh;
        longint r;
        longint lim_out;
        sh = ANGLE_Q - ANGLE_FRACTION_BITS;
        if (a > lim)
        begin
            a = lim;
        end
        if (a < -lim)
        begin
            a = -lim;
        end
        r       = (a + (longint'(1) <<< (sh - 1))) >>> sh;
        lim_out = lim >>> sh;
        if (r > lim_out)
        begin
            r = lim_out;
        end
        if (r < -lim_out)
        begin
            r = -lim_out;
        end
        return r;
    endfunction

    // Predicts roll = atan2(y, z) and pitch = atan2(-x, |y, z|) for one sample.
    function automatic tilt_t compute_tilt(input logic signed [SAMPLE_W-1:0] ax,
                                           input logic signed [SAMPLE_W-1:0] ay,
                                           input logic signed [SAMPLE_W-1:0] az);
        longint sx;
        longint sy;
        longint sz;
        longint vx;
        longint vy;
        longint t;
        longint ang;
        longint mag;
        longint nx;
        longint roll;
        longint pitch;
        tilt_t  res;
        sx  = ax;
        sy  = ay;
        sz  = az;
        vx  = sz * 256;
        vy  = sy * 256;
        ang = 0;
        // Left half-plane: pre-rotate by a quarter turn.
        if (vx < 0)
        begin
            t = vx;
            if (vy >= 0)
            begin
                vx  = vy;
                vy  = -t;
                ang = DEG90_Q16;
            end
            else
            begin
                vx  = -vy;
                vy  = t;
                ang = -DEG90_Q16;
            end
        end
        cordic_vectoring(vx, vy, ang);
        mag = vx;
        if (sy == 0 && sz == 0)
        begin
            roll = 0;
        end
        else
        begin
            roll = round_angle(ang, DEG180_Q16);
        end
        // The gain-scaled -x term cancels the CORDIC gain in the magnitude.
        nx = (-(sx * 256 * GAIN_Q16) + 32768) >>> 16;
        if (sx == 0 && sy == 0 && sz == 0)
        begin
            pitch = 0;
        end
        else
        begin
            vx  = mag;
            vy  = nx;
            ang = 0;
            cordic_vectoring(vx, vy, ang);
            pitch = round_angle(ang, DEG90_Q16);
        end
        res.roll  = roll[ROLL_W-1:0];
        res.pitch = pitch[PITCH_W-1:0];
        return res;
    endfunction

    // Sends one sample; the sender pauses between bursts unless it is calm.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] ax,
                               input logic signed [SAMPLE_W-1:0] ay,
                               input logic signed [SAMPLE_W-1:0] az);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap        = sender_calm ? 0 : $urandom_range(0, 7);
            if (gap > 0)
            begin
                sample_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left = burst_left - 1;
        sample_valid <= 1'b1;
        accel_x      <= ax;
        accel_y      <= ay;
        accel_z      <= az;
        @(posedge clk);
        while (sample_stall)
        begin
            @(posedge clk);
        end
        pending_tilt_q.push_back(compute_tilt(ax, ay, az));
    endtask

    // Holds off the sender until every expected result has come back.
    task automatic wait_for_drain();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_tilt_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // Random axis value: mostly full range, with small values and extremes.
    function automatic logic signed [SAMPLE_W-1:0] rand_axis();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 11)
        begin
            return SAMPLE_W'($urandom);
        end
        else if (pick < 14)
        begin
            return SAMPLE_W'($urandom_range(0, 128) - 64);
        end
        else if (pick < 17)
        begin
            return SAMPLE_W'($urandom_range(0, 4096) - 2048);
        end
        else
        begin
            case ($urandom_range(0, 4))
                0:       return 16'sh8000;
                1:       return 16'sh7FFF;
                2:       return 16'sh0000;
                3:       return 16'shFFFF;
                default: return 16'sh0001;
            endcase
        end
    endfunction

    // Zero vectors: the all-zero sample (roll and pitch zero), and y = z = 0 alone.
    task automatic test_zero_vectors();
        send_sample(16'sh0000, 16'sh0000, 16'sh0000);
        send_sample(-16'sd32768, 16'sh0000, 16'sh0000);
        send_sample(16'sd32767, 16'sh0000, 16'sh0000);
        send_sample(16'sh0001, 16'sh0000, 16'sh0000);
        send_sample(-16'sd1, 16'sh0000, 16'sh0000);
    endtask

    // Axis extremes, including atan2(0, negative) giving +180.
    task automatic test_axis_extremes();
        send_sample(16'sh0000, 16'sh0000, 16'sd32767);
        send_sample(16'sh0000, 16'sh0000, -16'sd32768);
        send_sample(16'sh0000, 16'sh0000, -16'sd1);
        send_sample(16'sh0000, 16'sd32767, 16'sh0000);
        send_sample(16'sh0000, -16'sd32768, 16'sh0000);
        send_sample(16'sd32767, 16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, -16'sd32768, -16'sd32768);
        send_sample(-16'sd32768, 16'sh0001, 16'sh0000);
        send_sample(16'sd32767, 16'sh0000, 16'sh0001);
    endtask

    // Left half-plane and angles near the +-180 clamp.
    task automatic test_quadrants();
        send_sample(16'sh0000, -16'sd1, -16'sd32768);
        send_sample(16'sh0000, 16'sh0001, -16'sd32768);
        send_sample(16'sh0001, 16'sh0001, -16'sd1);
        send_sample(-16'sd1, -16'sd1, -16'sd1);
        send_sample(16'sd1000, -16'sd20000, -16'sd15000);
        send_sample(-16'sd32768, 16'sd32767, -16'sd32768);
        send_sample(16'sd12345, 16'sd23456, 16'sd5);
        send_sample(-16'sd5, -16'sd3, 16'sd2);
    endtask

    // Long random stream with calm stretches and periodic full drains.
    task automatic test_random_stream(input int count);
        for (int n = 0; n < count; n++)
        begin
            if (n % 250 == 0)
            begin
                sender_calm = ($urandom_range(0, 2) == 0);
            end
            if (n % 437 == 436)
            begin
                wait_for_drain();
            end
            send_sample(rand_axis(), rand_axis(), rand_axis());
        end
    endtask

    // Receiver stall patterns: none, light, heavy, periodic and long holds.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode <= $urandom_range(0, 4);
            stall_left <= $urandom_range(20, 200);
        end
        else
        begin
            stall_left <= stall_left - 1;
        end
        case (stall_mode)
            0:       angle_stall <= 1'b0;
            1:       angle_stall <= ($urandom_range(0, 3) == 0);
            2:       angle_stall <= ($urandom_range(0, 9) < 7);
            3:       angle_stall <= (cycle_count % 5 < 2);
            default: angle_stall <= (stall_left > 40);
        endcase
    end

    // Result checker: each transfer against the oldest expectation.
    always @(posedge clk)
    begin
        tilt_t want;
        if (rst_n && angle_valid && !angle_stall)
        begin
            if (pending_tilt_q.size() == 0)
            begin
                $display("%0t: unexpected result roll %0d pitch %0d",
                         $time, roll_angle, pitch_angle);
                fault_count = fault_count + 1;
            end
            else
            begin
                want = pending_tilt_q.pop_front();
                if (roll_angle !== want.roll)
                begin
                    $display("%0t: roll_angle expected %0d actual %0d",
                             $time, want.roll, roll_angle);
                    fault_count = fault_count + 1;
                end
                if (pitch_angle !== want.pitch)
                begin
                    $display("%0t: pitch_angle expected %0d actual %0d",
                             $time, want.pitch, pitch_angle);
                    fault_count = fault_count + 1;
                end
            end
        end
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: run limit reached with %0d results outstanding",
                     $time, pending_tilt_q.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // Test sequence.
    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_vectors();
        test_axis_extremes();
        test_quadrants();
        test_random_stream(1750);
        sample_valid <= 1'b0;
        @(posedge clk);
        while (pending_tilt_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fault_count == 0)
        begin
            $display("tb_top: done, clean");
        end
        else
        begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule

>>> sim.f
rtl/atrp_pkg.sv
rtl/atrp_pre.sv
rtl/atrp_cordic.sv
rtl/atrp_mid.sv
rtl/atrp_post.sv
rtl/accel_tilt_roll_pitch.sv
rtl/atrp_checker.sv
verif/tb_top.sv
